// File: sv/psu_pkg.sv
package psu_pkg;

	localparam int MAX_ENTRIES_DEF = 1024;

	localparam int SIZE_W      = 11;
	localparam int POS_W       = 10;
	localparam int ELEM_W      = 10;
	localparam int ST_W        = 2;
	localparam int REQ_W       = 2;
	localparam int RAND_W      = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_DRAW = 2'd0;
	localparam logic [REQ_W-1:0] REQ_UNDO = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	// result status
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_ALL_DRAWN = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_UNDO   = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

	// register index (word address bit)
	localparam logic REG_ACTIVE_SIZE = 1'b0;
	localparam logic REG_FROM_BACK   = 1'b1;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic addr;
		logic data;
		logic wb;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic err_now;
		logic swap;
	} dp_status_t;

endpackage

// File: sv/psu_ram.sv
module psu_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: sv/psu_cfg.sv
module psu_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [psu_pkg::APB_AW-1:0]   paddr,
	input  logic [psu_pkg::APB_DW-1:0]   pwdata,
	output logic [psu_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output logic [psu_pkg::SIZE_W-1:0]   active_size,
	output logic                         from_back
);

	logic [psu_pkg::SIZE_W-1:0] active_size_q;
	logic                       from_back_q;
	logic                       wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= psu_pkg::SIZE_RESET;
			from_back_q   <= 1'b0;
		end else if (wr) begin
			unique case (paddr[2])
				psu_pkg::REG_ACTIVE_SIZE: active_size_q <= pwdata[psu_pkg::SIZE_W-1:0];
				psu_pkg::REG_FROM_BACK:   from_back_q   <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			psu_pkg::REG_ACTIVE_SIZE: prdata = {{(psu_pkg::APB_DW-psu_pkg::SIZE_W){1'b0}},
				active_size_q};
			psu_pkg::REG_FROM_BACK:   prdata = {{(psu_pkg::APB_DW-1){1'b0}}, from_back_q};
		endcase
	end

	assign active_size = active_size_q;
	assign from_back   = from_back_q;

endmodule

// File: sv/psu_dp.sv
module psu_dp #(
	parameter int MAX_ENTRIES = psu_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  psu_pkg::ctrl_cmd_t                cmd,
	output psu_pkg::dp_status_t               sts,
	input  logic [psu_pkg::SIZE_W-1:0]        active_size,
	input  logic                              from_back,
	input  logic [psu_pkg::REQ_W-1:0]         in_tuser,
	input  logic [psu_pkg::IN_TDATA_W-1:0]    in_tdata,
	output logic [psu_pkg::OUT_TDATA_W-1:0]   out_tdata,
	output logic [psu_pkg::ST_W-1:0]          out_tuser
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (NW > psu_pkg::SIZE_W) ? NW : psu_pkg::SIZE_W;
	localparam int PW = psu_pkg::POS_W;

	// control state
	logic [NW-1:0] i_q;
	logic [AW-1:0] clr_q;

	// per-request registers
	logic [psu_pkg::REQ_W-1:0] req_q;
	logic [PW-1:0]             rp_q;
	logic [NW-1:0]             j_q;
	logic [psu_pkg::ST_W-1:0]  st_q;
	logic [AW-1:0]             pos_q;
	logic [AW-1:0]             partner_q;
	logic [AW-1:0]             hold_q;
	logic [AW-1:0]             elem_q;
	logic [PW-1:0]             out_pos_q;
	logic [psu_pkg::ELEM_W-1:0] out_elem_q;
	logic [psu_pkg::ST_W-1:0]  out_st_q;

	logic [psu_pkg::REQ_W-1:0]  req_in;
	logic [psu_pkg::RAND_W-1:0] r_in;
	logic [PW-1:0]              rp_in;

	logic [CW-1:0] act_c, max_c, n_c, i_c, rp_c;
	logic [NW-1:0] n;
	logic [NW-1:0] diff;
	logic [psu_pkg::RAND_W+NW-1:0] prod;
	logic [psu_pkg::ST_W-1:0] st_now;

	logic [NW-1:0] k;
	logic [NW:0]   sum_w, wrap_w;
	logic [NW-1:0] back_pos, front_partner;
	logic [AW+PW-1:0] rp_ext, pos_ext, elem_ext;
	logic [AW-1:0] pos_nxt, partner_nxt;
	logic          swap_q;

	logic          perm_we;
	logic [AW-1:0] perm_waddr, perm_wdata, perm_rd_a, perm_rd_b;
	logic [AW-1:0] perm_rdata_a, perm_rdata_b;
	logic          log_we;
	logic [AW-1:0] log_rdata;

	assign req_in = in_tuser;
	assign r_in   = in_tdata[psu_pkg::RAND_W-1:0];
	assign rp_in  = in_tdata[psu_pkg::RAND_W+PW-1:psu_pkg::RAND_W];

	// effective size, saturated at the store depth
	assign act_c = CW'(active_size);
	assign max_c = CW'(MAX_ENTRIES);
	assign n_c   = (act_c > max_c) ? max_c : act_c;
	assign n     = n_c[NW-1:0];
	assign i_c   = CW'(i_q);
	assign rp_c  = CW'(rp_in);

	assign diff = n - i_q;
	assign prod = {{NW{1'b0}}, r_in} * {{psu_pkg::RAND_W{1'b0}}, diff};

	always_comb begin
		case (req_in)
			psu_pkg::REQ_DRAW: st_now = (i_c >= n_c) ? psu_pkg::ST_ALL_DRAWN : psu_pkg::ST_OK;
			psu_pkg::REQ_UNDO: st_now = (i_q == '0) ? psu_pkg::ST_NO_UNDO : psu_pkg::ST_OK;
			default:           st_now = (rp_c >= n_c) ? psu_pkg::ST_RANGE : psu_pkg::ST_OK;
		endcase
	end

	assign swap_q = (req_q == psu_pkg::REQ_DRAW) || (req_q == psu_pkg::REQ_UNDO);

	assign sts.clr_last = (clr_q == AW'(MAX_ENTRIES - 1));
	assign sts.err_now  = (st_now != psu_pkg::ST_OK);
	assign sts.swap     = swap_q;

	// swap addresses
	assign k             = i_q - 1'b1;
	assign sum_w         = {1'b0, n} + (NW+1)'(MAX_ENTRIES) - {1'b0, i_q};
	assign wrap_w        = (sum_w >= (NW+1)'(MAX_ENTRIES)) ? sum_w - (NW+1)'(MAX_ENTRIES) : sum_w;
	assign back_pos      = n - 1'b1 - i_q;
	assign front_partner = i_q + j_q;
	assign rp_ext        = {{AW{1'b0}}, rp_q};

	always_comb begin
		case (req_q)
			psu_pkg::REQ_DRAW: begin
				pos_nxt     = from_back ? back_pos[AW-1:0] : i_q[AW-1:0];
				partner_nxt = from_back ? j_q[AW-1:0] : front_partner[AW-1:0];
			end
			psu_pkg::REQ_UNDO: begin
				pos_nxt     = from_back ? wrap_w[AW-1:0] : k[AW-1:0];
				partner_nxt = log_rdata;
			end
			default: begin
				pos_nxt     = rp_ext[AW-1:0];
				partner_nxt = rp_ext[AW-1:0];
			end
		endcase
	end

	assign perm_rd_a = pos_nxt;
	assign perm_rd_b = partner_nxt;

	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = pos_q;
		perm_wdata = elem_q;
		if (cmd.clr_step) begin
			perm_we    = 1'b1;
			perm_waddr = clr_q;
			perm_wdata = clr_q;
		end else if (cmd.data && swap_q) begin
			perm_we    = 1'b1;
			perm_waddr = pos_q;
			perm_wdata = perm_rdata_b;
		end else if (cmd.wb) begin
			perm_we    = 1'b1;
			perm_waddr = partner_q;
			perm_wdata = hold_q;
		end
	end

	psu_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_perm (
		.clk     (clk),
		.we      (perm_we),
		.waddr   (perm_waddr),
		.wdata   (perm_wdata),
		.raddr_a (perm_rd_a),
		.raddr_b (perm_rd_b),
		.rdata_a (perm_rdata_a),
		.rdata_b (perm_rdata_b)
	);

	assign log_we = cmd.data && (req_q == psu_pkg::REQ_DRAW);

	psu_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_log (
		.clk     (clk),
		.we      (log_we),
		.waddr   (i_q[AW-1:0]),
		.wdata   (partner_q),
		.raddr_a (k[AW-1:0]),
		.raddr_b (k[AW-1:0]),
		.rdata_a (log_rdata),
		.rdata_b ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.wb) begin
				i_q <= (req_q == psu_pkg::REQ_DRAW) ? i_q + 1'b1 : k;
			end
		end
	end

	assign pos_ext  = {{PW{1'b0}}, pos_q};
	assign elem_ext = {{PW{1'b0}}, elem_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_in;
			rp_q  <= rp_in;
			j_q   <= prod[psu_pkg::RAND_W+NW-1:psu_pkg::RAND_W];
			st_q  <= st_now;
		end
		if (cmd.addr) begin
			pos_q     <= pos_nxt;
			partner_q <= partner_nxt;
		end
		if (cmd.data) begin
			elem_q <= swap_q ? perm_rdata_b : perm_rdata_a;
			hold_q <= perm_rdata_a;
		end
		if (cmd.load) begin
			out_st_q <= st_q;
			if ((st_q == psu_pkg::ST_ALL_DRAWN) || (st_q == psu_pkg::ST_NO_UNDO)) begin
				out_pos_q <= '0;
			end else if (!swap_q) begin
				out_pos_q <= rp_q;
			end else begin
				out_pos_q <= pos_ext[PW-1:0];
			end
			out_elem_q <= (st_q != psu_pkg::ST_OK) ? '0 : elem_ext[psu_pkg::ELEM_W-1:0];
		end
	end

	assign out_tdata = {{(psu_pkg::OUT_TDATA_W-PW-psu_pkg::ELEM_W){1'b0}}, out_elem_q, out_pos_q};
	assign out_tuser = out_st_q;

endmodule

// File: sv/psu_ctrl.sv
module psu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output psu_pkg::ctrl_cmd_t  cmd,
	input  psu_pkg::dp_status_t sts
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_ADDR  = 6'b000100,
		S_DATA  = 6'b001000,
		S_WB    = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	logic   m_tvalid_q;

	always_comb begin
		cmd          = '0;
		state_nxt    = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nxt  = sts.err_now ? S_FIN : S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.addr  = 1'b1;
				state_nxt = S_DATA;
			end
			S_DATA: begin
				cmd.data  = 1'b1;
				state_nxt = sts.swap ? S_WB : S_FIN;
			end
			S_WB: begin
				cmd.wb    = 1'b1;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

// File: sv/partial_shuffle_with_undo.sv
// channel   dir  handshake          payload
// s         in   s_tvalid/s_tready  tdata: random_fraction, read_position; tuser: req_type
// m         out  m_tvalid/m_tready  tdata: position, element; tuser: status
// apb       in   psel/penable       active_size at 0x0, from_back at 0x4
//
// draw and undo go ADDR, DATA, WB, FIN from accept to result register, a read skips WB,
// a refused request goes to FIN; the swap writes the store's write port in DATA and WB
// after reset the store is loaded with the identity while s_tready is low
// a result held in the output register does not block the next accept; only the load of
// the next result into the output register waits for m_tready
module partial_shuffle_with_undo #(
	parameter int MAX_ENTRIES = psu_pkg::MAX_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [psu_pkg::IN_TDATA_W-1:0]  s_tdata,  // random_fraction, read_position
	input  logic [psu_pkg::REQ_W-1:0]       s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [psu_pkg::OUT_TDATA_W-1:0] m_tdata,  // position, element
	output logic [psu_pkg::ST_W-1:0]        m_tuser,  // status
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [psu_pkg::APB_AW-1:0]      paddr,
	input  logic [psu_pkg::APB_DW-1:0]      pwdata,
	output logic [psu_pkg::APB_DW-1:0]      prdata,
	output logic                            pready
);

	psu_pkg::ctrl_cmd_t         cmd;
	psu_pkg::dp_status_t        sts;
	logic [psu_pkg::SIZE_W-1:0] active_size;
	logic                       from_back;

	psu_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.active_size (active_size),
		.from_back   (from_back)
	);

	psu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	psu_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.active_size (active_size),
		.from_back   (from_back),
		.in_tuser    (s_tuser),
		.in_tdata    (s_tdata),
		.out_tdata   (m_tdata),
		.out_tuser   (m_tuser)
	);

endmodule

// File: sv/psu_checker.sv
module psu_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [psu_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [psu_pkg::ST_W-1:0]        m_tuser,
	input logic                            pready
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted back to back");

	// refused draw or undo reports zero position and element
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == psu_pkg::ST_ALL_DRAWN || m_tuser == psu_pkg::ST_NO_UNDO)
		|-> m_tdata == '0)
		else $error("refused request carries data");

	// out of range read has no element
	a_range_elem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == psu_pkg::ST_RANGE |-> m_tdata[19:10] == '0)
		else $error("out of range read carries element");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind partial_shuffle_with_undo psu_checker u_psu_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import psu_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned PHASES = 12;
	localparam int unsigned ITEMS_PER_PHASE = 36;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [ELEM_W-1:0] elem;
		logic [ST_W-1:0]   st;
	} shuffle_result_t;

	class shuffle_scoreboard;
		logic [ELEM_W-1:0] perm [MAX_ENTRIES_DEF];
		logic [POS_W-1:0]  partner_log [MAX_ENTRIES_DEF];
		int unsigned       draws;
		int unsigned       size_reg;
		bit                back;
		shuffle_result_t   pending [$];
		int                errors;

		function new();
			for (int k = 0; k < MAX_ENTRIES_DEF; k++) begin
				perm[k] = ELEM_W'(k);
				partner_log[k] = '0;
			end
			draws = 0;
			size_reg = SIZE_RESET;
			back = 1'b0;
			errors = 0;
		endfunction

		function int unsigned live_size();
			return (size_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : size_reg;
		endfunction

		function void swap_slots(int unsigned a, int unsigned b);
			logic [ELEM_W-1:0] t;
			t = perm[a];
			perm[a] = perm[b];
			perm[b] = t;
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic [RAND_W-1:0] frac,
				logic [POS_W-1:0] rpos);
			int unsigned     n;
			int unsigned     pos;
			int unsigned     mate;
			int unsigned     k;
			longint unsigned prod;
			shuffle_result_t res;
			n = live_size();
			res = '0;
			if (req == REQ_DRAW) begin
				if (draws >= n) begin
					res.st = ST_ALL_DRAWN;
				end else begin
					prod = {32'd0, frac};
					prod = prod * (n - draws);
					mate = int'(prod >> 32);
					if (back) begin
						pos = n - 1 - draws;
					end else begin
						pos = draws;
						mate = draws + mate;
					end
					swap_slots(pos, mate);
					partner_log[draws] = POS_W'(mate);
					draws++;
					res.pos = POS_W'(pos);
					res.elem = perm[pos];
					res.st = ST_OK;
				end
			end else if (req == REQ_UNDO) begin
				if (draws == 0) begin
					res.st = ST_NO_UNDO;
				end else begin
					k = draws - 1;
					mate = partner_log[k];
					if (back)
						pos = (n + MAX_ENTRIES_DEF - draws) % MAX_ENTRIES_DEF;
					else
						pos = k;
					swap_slots(pos, mate);
					draws = k;
					res.pos = POS_W'(pos);
					res.elem = perm[pos];
					res.st = ST_OK;
				end
			end else begin
				res.pos = rpos;
				if (rpos >= n) begin
					res.st = ST_RANGE;
				end else begin
					res.elem = perm[rpos];
					res.st = ST_OK;
				end
			end
			pending.push_back(res);
		endfunction

		function void check_result(logic [POS_W-1:0] pos, logic [ELEM_W-1:0] elem,
				logic [ST_W-1:0] st);
			shuffle_result_t want;
			if (pending.size() == 0) begin
				$error("result with no request waiting: position %0d element %0d status %0d",
					pos, elem, st);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (pos !== want.pos) begin
				$error("position: expected %0d, got %0d", want.pos, pos);
				errors++;
			end
			if (elem !== want.elem) begin
				$error("element: expected %0d, got %0d", want.elem, elem);
				errors++;
			end
			if (st !== want.st) begin
				$error("status: expected %0d, got %0d", want.st, st);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [REQ_W-1:0]       s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]        m_tuser;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	shuffle_scoreboard board = new();
	bit                sender_quiet;
	bit                sink_quiet;
	int unsigned       hold_left;
	int unsigned       cycles;

	partial_shuffle_with_undo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result sink with random back-pressure
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left--;
		else if (!sink_quiet)
			hold_left = pick_gap();
		m_tready <= (hold_left == 0);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata[0 +: POS_W], m_tdata[POS_W +: ELEM_W], m_tuser);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_request(input logic [REQ_W-1:0] req, input logic [RAND_W-1:0] frac,
			input logic [POS_W-1:0] rpos);
		int unsigned gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'({rpos, frac});
		s_tuser <= req;
		do @(posedge clk); while (!s_tready);
		board.note_request(req, frac, rpos);
	endtask

	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_ACTIVE_SIZE)
			board.size_reg = data[SIZE_W-1:0];
		else
			board.back = data[0];
	endtask

	task automatic configure(input logic [APB_DW-1:0] size_word, input bit from_end);
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!s_tready) @(posedge clk);
		write_reg(REG_ACTIVE_SIZE, size_word);
		write_reg(REG_FROM_BACK, {{(APB_DW-1){1'b0}}, from_end});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_request();
		int unsigned       n;
		int unsigned       roll;
		logic [REQ_W-1:0]  req;
		logic [RAND_W-1:0] frac;
		logic [POS_W-1:0]  rpos;
		n = board.live_size();
		roll = $urandom_range(0, 99);
		if (roll < 45)
			req = REQ_DRAW;
		else if (roll < 75)
			req = REQ_UNDO;
		else if (roll < 93)
			req = REQ_READ;
		else
			req = REQ_SPARE;
		case ($urandom_range(0, 9))
			0: frac = '0;
			1: frac = '1;
			2: frac = $urandom_range(0, 255);
			3: frac = 32'hFFFF_FF00 | $urandom_range(0, 255);
			default: frac = $urandom;
		endcase
		if (n > 0 && $urandom_range(0, 9) < 7)
			rpos = POS_W'($urandom_range(0, n - 1));
		else
			rpos = POS_W'($urandom);
		send_request(req, frac, rpos);
	endtask

	initial begin
		logic [APB_DW-1:0] size_word;
		bit                from_end;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_DRAW;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sender_quiet = 1'b0;
		sink_quiet = 1'b0;
		hold_left = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full size from the front
		configure(32'd1024, 1'b0);
		send_request(REQ_UNDO, 32'd0, 10'd0);
		send_request(REQ_READ, 32'd0, 10'd0);
		send_request(REQ_READ, 32'hFFFF_FFFF, 10'd1023);
		send_request(REQ_SPARE, 32'd0, 10'd512);
		send_request(REQ_DRAW, 32'd0, 10'd0);
		send_request(REQ_DRAW, 32'hFFFF_FFFF, 10'd0);
		send_request(REQ_UNDO, 32'd0, 10'd0);
		send_request(REQ_UNDO, 32'd0, 10'd0);
		send_request(REQ_UNDO, 32'd0, 10'd0);

		// zero size
		configure(32'd0, 1'b0);
		send_request(REQ_DRAW, 32'h8000_0000, 10'd0);
		send_request(REQ_READ, 32'd0, 10'd0);
		send_request(REQ_UNDO, 32'd0, 10'd0);

		// two entries from the back, then all drawn
		configure(32'd2, 1'b1);
		send_request(REQ_DRAW, 32'hFFFF_FFFF, 10'd0);
		send_request(REQ_DRAW, 32'd0, 10'd0);
		send_request(REQ_DRAW, 32'h1234_5678, 10'd0);
		send_request(REQ_READ, 32'd0, 10'd1);
		send_request(REQ_READ, 32'd0, 10'd2);
		send_request(REQ_READ, 32'd0, 10'd1023);

		// size shrunk below the draw count, undo position wraps
		configure(32'd1, 1'b1);
		send_request(REQ_UNDO, 32'd0, 10'd0);
		send_request(REQ_UNDO, 32'd0, 10'd0);
		send_request(REQ_DRAW, 32'hFFFF_FFFF, 10'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin size_word = 32'd1024; from_end = 1'b0; end
				1: begin size_word = 32'd5;    from_end = 1'b1; end
				2: begin size_word = 32'd2047; from_end = 1'b0; end
				3: begin size_word = 32'd3;    from_end = 1'b0; end
				4: begin size_word = 32'd1025; from_end = 1'b1; end
				5: begin size_word = 32'd1;    from_end = 1'b1; end
				6: begin size_word = 32'd0;    from_end = 1'b0; end
				7: begin size_word = 32'd16;   from_end = 1'b0; end
				default: begin
					size_word = ($urandom & 32'hFFFF_F800) | $urandom_range(1, 40);
					if ($urandom_range(0, 3) == 0)
						size_word[SIZE_W-1:0] = $urandom_range(0, 2047);
					from_end = $urandom_range(0, 1);
				end
			endcase
			configure(size_word, from_end);
			sender_quiet = (ph % 3 == 1);
			sink_quiet = (ph % 4 == 2);
			for (int it = 0; it < ITEMS_PER_PHASE; it++)
				random_request();
		end

		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
sv/psu_pkg.sv
sv/psu_ram.sv
sv/psu_cfg.sv
sv/psu_dp.sv
sv/psu_ctrl.sv
sv/partial_shuffle_with_undo.sv
sv/psu_checker.sv
sim/testbench.sv
